>>> src/qymd_pkg.sv
// shared widths, constants and the arctangent table for the yaw-to-move block
package qymd_pkg;

    localparam int QUAT_W       = 16;
    localparam int MUL_W        = 19;
    localparam int PROD_W       = 2 * MUL_W;
    localparam int ACC_W        = 33;
    localparam int NUM_W        = 36;
    localparam int XY_W         = 38;
    localparam int Z_W          = 21;
    localparam int YAW_W        = 20;
    localparam int DELTA_W      = YAW_W + 1;
    localparam int MAG_W        = 18;
    localparam int DEADBAND_W   = 16;
    localparam int GAIN_W       = 12;
    localparam int FRAC_W       = 16;
    localparam int MOVE_W       = 15;
    localparam int MV_W         = MAG_W + GAIN_W - FRAC_W;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 16;
    localparam int ATAN_LEN     = 24;
    localparam int ATAN_IDX_W   = 5;
    localparam int ATAN_W       = 16;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int PI_FIX           = 205887;
    localparam int TWO_PI_FIX       = 411774;
    localparam int MOVE_MAX         = 12868;
    localparam int Q28_ONE          = 1 << 28;
    localparam int DEADBAND_RST     = 66;
    localparam int GAIN_RST         = 1000;

    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN     = CFG_IDX_W'(1);

    typedef struct packed {
        logic busy;
        logic done;
    } cordic_stat_t;

    function automatic logic [ATAN_W-1:0] atan_lookup(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 16'd51472;
            5'd1:    v = 16'd30386;
            5'd2:    v = 16'd16055;
            5'd3:    v = 16'd8150;
            5'd4:    v = 16'd4091;
            5'd5:    v = 16'd2047;
            5'd6:    v = 16'd1024;
            5'd7:    v = 16'd512;
            5'd8:    v = 16'd256;
            5'd9:    v = 16'd128;
            5'd10:   v = 16'd64;
            5'd11:   v = 16'd32;
            5'd12:   v = 16'd16;
            5'd13:   v = 16'd8;
            5'd14:   v = 16'd4;
            5'd15:   v = 16'd2;
            5'd16:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

>>> src/qymd_mul.sv
// shared signed multiplier with registered product
module qymd_mul (
    input  logic                                aclk,
    input  logic                                en,
    input  logic signed [qymd_pkg::MUL_W-1:0]   a,
    input  logic signed [qymd_pkg::MUL_W-1:0]   b,
    output logic signed [qymd_pkg::PROD_W-1:0]  p
);
    import qymd_pkg::*;

    logic signed [PROD_W-1:0] p_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= a * b;
        end
    end

    assign p = p_reg;

endmodule

>>> src/qymd_cordic.sv
// iterative vectoring cordic, one micro-rotation per cycle, yields clamped yaw
module qymd_cordic #(
    parameter int CORDIC_STEPS = qymd_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [qymd_pkg::NUM_W-1:0]   num,
    input  logic signed [qymd_pkg::NUM_W-1:0]   den,
    output qymd_pkg::cordic_stat_t              stat,
    output logic signed [qymd_pkg::YAW_W-1:0]   yaw
);
    import qymd_pkg::*;

    localparam int RUN_STEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
    localparam int CNT_W     = $clog2(RUN_STEPS + 1);

    logic signed [XY_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [XY_W-1:0] xs, ys, x_in, y_in;
    logic signed [Z_W-1:0]  z_reg, z_next, ang;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   run_reg, run_next, done_reg, done_next;

    assign x_in = XY_W'(den);
    assign y_in = XY_W'(num);
    assign xs   = x_reg >>> cnt_reg;
    assign ys   = y_reg >>> cnt_reg;
    assign ang  = $signed(Z_W'(atan_lookup(ATAN_IDX_W'(cnt_reg))));

    always_comb begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start) begin
            cnt_next = '0;
            if (den == '0 && num == '0) begin
                x_next    = '0;
                y_next    = '0;
                z_next    = '0;
                run_next  = 1'b0;
                done_next = 1'b1;
            end else if (den < 0) begin
                x_next   = -x_in;
                y_next   = -y_in;
                z_next   = (num >= 0) ? Z_W'(PI_FIX) : -Z_W'(PI_FIX);
                run_next = 1'b1;
            end else begin
                x_next   = x_in;
                y_next   = y_in;
                z_next   = '0;
                run_next = 1'b1;
            end
        end else if (run_reg) begin
            if (y_reg >= 0) begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + ang;
            end else begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - ang;
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(RUN_STEPS - 1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    // clamp residue into +-pi
    always_comb begin
        if (z_reg > Z_W'(PI_FIX)) begin
            yaw = YAW_W'(PI_FIX);
        end else if (z_reg < -Z_W'(PI_FIX)) begin
            yaw = -YAW_W'(PI_FIX);
        end else begin
            yaw = z_reg[YAW_W-1:0];
        end
    end

    assign stat.busy = run_reg;
    assign stat.done = done_reg;

endmodule

>>> src/quaternion_yaw_to_mouse_delta_core.sv
// head yaw from quaternion to horizontal mouse move, sequenced over a shared multiplier and cordic
//
//  channel | ports                                  | dir | beat
//  --------+----------------------------------------+-----+-------------------------------
//  s_      | s_valid s_ready s_quat_w/x/y/z         | in  | one quaternion, Q1.14
//  m_      | m_valid m_ready m_move_x               | out | one move count, zero or one per input
//  cfg_    | cfg_valid cfg_ready cfg_index cfg_data | in  | register write, 0 deadband, 1 gain
//
//  a move follows its input beat through four multiplier passes, the cordic load, one rotation
//  per cycle, the yaw capture, the wrap, then the gain product. s_ready returns when the move is
//  written, or after the wrap when the change is inside the deadband and nothing is emitted; no
//  new beat is taken while one is in flight.
//  a waiting m_ beat does not block intake, only the final write of the next result.
//  reset sets deadband 66, gain 1000, last yaw 0. cfg_ready is always high.
module quaternion_yaw_to_mouse_delta_core #(
    parameter int CORDIC_STEPS = qymd_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [qymd_pkg::QUAT_W-1:0]      s_quat_w,
    input  logic signed [qymd_pkg::QUAT_W-1:0]      s_quat_x,
    input  logic signed [qymd_pkg::QUAT_W-1:0]      s_quat_y,
    input  logic signed [qymd_pkg::QUAT_W-1:0]      s_quat_z,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [qymd_pkg::MOVE_W-1:0]      m_move_x,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [qymd_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [qymd_pkg::CFG_DATA_W-1:0]         cfg_data
);
    import qymd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_M1, S_M2, S_M3, S_M4, S_LOAD, S_CORDIC, S_DELTA, S_SCALE
    } state_t;

    state_t                    state_reg, state_next;
    logic signed [QUAT_W-1:0]  qx_reg, qx_next, qy_reg, qy_next, qz_reg, qz_next;
    logic signed [ACC_W-1:0]   num_acc_reg, num_acc_next, den_acc_reg, den_acc_next;
    logic signed [YAW_W-1:0]   yaw_reg, yaw_next, last_yaw_reg, last_yaw_next;
    logic                      neg_reg, neg_next;
    logic                      m_valid_reg, m_valid_next;
    logic signed [MOVE_W-1:0]  move_reg, move_next;
    logic [DEADBAND_W-1:0]     deadband_reg, deadband_next;
    logic [GAIN_W-1:0]         gain_reg, gain_next;

    logic                      mul_en;
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  mul_p;

    logic                      cordic_start;
    logic signed [NUM_W-1:0]   cordic_num, cordic_den;
    cordic_stat_t              cordic_stat;
    logic signed [YAW_W-1:0]   cordic_yaw;

    logic signed [DELTA_W-1:0] delta_raw, delta_wrap, delta_abs;
    logic [MAG_W-1:0]          mag;
    logic [MV_W-1:0]           mv, mv_sat;

    qymd_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    qymd_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .num     (cordic_num),
        .den     (cordic_den),
        .stat    (cordic_stat),
        .yaw     (cordic_yaw)
    );

    assign cordic_num = NUM_W'(num_acc_reg) <<< 1;
    assign cordic_den = NUM_W'(Q28_ONE) - (NUM_W'(den_acc_reg) <<< 1);

    // yaw difference wrapped into +-pi
    assign delta_raw = DELTA_W'(yaw_reg) - DELTA_W'(last_yaw_reg);
    always_comb begin
        if (delta_raw > DELTA_W'(PI_FIX)) begin
            delta_wrap = delta_raw - DELTA_W'(TWO_PI_FIX);
        end else if (delta_raw < -DELTA_W'(PI_FIX)) begin
            delta_wrap = delta_raw + DELTA_W'(TWO_PI_FIX);
        end else begin
            delta_wrap = delta_raw;
        end
    end
    assign delta_abs = (delta_wrap < 0) ? -delta_wrap : delta_wrap;
    assign mag       = delta_abs[MAG_W-1:0];

    assign mv     = mul_p[MAG_W+GAIN_W-1:FRAC_W];
    assign mv_sat = (mv > MV_W'(MOVE_MAX)) ? MV_W'(MOVE_MAX) : mv;

    always_comb begin
        state_next    = state_reg;
        qx_next       = qx_reg;
        qy_next       = qy_reg;
        qz_next       = qz_reg;
        num_acc_next  = num_acc_reg;
        den_acc_next  = den_acc_reg;
        yaw_next      = yaw_reg;
        last_yaw_next = last_yaw_reg;
        neg_next      = neg_reg;
        move_next     = move_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        deadband_next = deadband_reg;
        gain_next     = gain_reg;
        mul_en        = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        cordic_start  = 1'b0;

        if (cfg_valid) begin
            case (cfg_index)
                REG_DEADBAND: deadband_next = cfg_data[DEADBAND_W-1:0];
                REG_GAIN:     gain_next     = cfg_data[GAIN_W-1:0];
                default:      ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    qx_next    = s_quat_x;
                    qy_next    = s_quat_y;
                    qz_next    = s_quat_z;
                    mul_en     = 1'b1;
                    mul_a      = MUL_W'(s_quat_w);
                    mul_b      = MUL_W'(s_quat_y);
                    state_next = S_M1;
                end
            end
            S_M1: begin
                num_acc_next = ACC_W'(mul_p);
                mul_en       = 1'b1;
                mul_a        = MUL_W'(qz_reg);
                mul_b        = MUL_W'(qx_reg);
                state_next   = S_M2;
            end
            S_M2: begin
                num_acc_next = num_acc_reg + ACC_W'(mul_p);
                mul_en       = 1'b1;
                mul_a        = MUL_W'(qy_reg);
                mul_b        = MUL_W'(qy_reg);
                state_next   = S_M3;
            end
            S_M3: begin
                den_acc_next = ACC_W'(mul_p);
                mul_en       = 1'b1;
                mul_a        = MUL_W'(qz_reg);
                mul_b        = MUL_W'(qz_reg);
                state_next   = S_M4;
            end
            S_M4: begin
                den_acc_next = den_acc_reg + ACC_W'(mul_p);
                state_next   = S_LOAD;
            end
            S_LOAD: begin
                cordic_start = 1'b1;
                state_next   = S_CORDIC;
            end
            S_CORDIC: begin
                if (cordic_stat.done) begin
                    yaw_next   = cordic_yaw;
                    state_next = S_DELTA;
                end
            end
            S_DELTA: begin
                if (mag > MAG_W'(deadband_reg)) begin
                    neg_next   = delta_wrap < 0;
                    mul_en     = 1'b1;
                    mul_a      = $signed(MUL_W'(mag));
                    mul_b      = $signed(MUL_W'(gain_reg));
                    state_next = S_SCALE;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_SCALE: begin
                if (!m_valid_reg || m_ready) begin
                    move_next     = neg_reg ? -$signed(MOVE_W'(mv_sat))
                                            : $signed(MOVE_W'(mv_sat));
                    m_valid_next  = 1'b1;
                    last_yaw_next = yaw_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_valid_reg  <= 1'b0;
            last_yaw_reg <= '0;
            deadband_reg <= DEADBAND_W'(DEADBAND_RST);
            gain_reg     <= GAIN_W'(GAIN_RST);
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            last_yaw_reg <= last_yaw_next;
            deadband_reg <= deadband_next;
            gain_reg     <= gain_next;
        end
        qx_reg      <= qx_next;
        qy_reg      <= qy_next;
        qz_reg      <= qz_next;
        num_acc_reg <= num_acc_next;
        den_acc_reg <= den_acc_next;
        yaw_reg     <= yaw_next;
        neg_reg     <= neg_next;
        move_reg    <= move_next;
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_move_x  = move_reg;
    assign cfg_ready = 1'b1;

    a_rose_from_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == S_SCALE))
        else $error("result appeared outside the scale step");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while sequencer busy");

    a_cordic_in_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        cordic_stat.busy || cordic_stat.done |-> state_reg == S_CORDIC)
        else $error("cordic active outside its phase");

    a_yaw_held_on_skip: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DELTA && mag <= MAG_W'(deadband_reg) |=> $stable(last_yaw_reg))
        else $error("stored yaw changed inside deadband");

endmodule

>>> tb/qymd_checker.sv
// checker for the yaw-to-move core: follows every beat, predicts each move and compares
module qymd_checker #(
    parameter int CORDIC_STEPS = qymd_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    input  logic                                    s_ready,
    input  logic signed [qymd_pkg::QUAT_W-1:0]      s_quat_w,
    input  logic signed [qymd_pkg::QUAT_W-1:0]      s_quat_x,
    input  logic signed [qymd_pkg::QUAT_W-1:0]      s_quat_y,
    input  logic signed [qymd_pkg::QUAT_W-1:0]      s_quat_z,
    input  logic                                    m_valid,
    input  logic                                    m_ready,
    input  logic signed [qymd_pkg::MOVE_W-1:0]      m_move_x,
    input  logic                                    cfg_valid,
    input  logic                                    cfg_ready,
    input  logic [qymd_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [qymd_pkg::CFG_DATA_W-1:0]         cfg_data,
    output int                                      moves_pending,
    output int                                      mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import qymd_pkg::*;

    localparam longint HALF_TURN      = 205887;
    localparam longint FULL_TURN      = 411774;
    localparam longint MOVE_LIMIT     = 12868;
    localparam int     DEADBAND_INIT  = 66;
    localparam int     GAIN_INIT      = 1000;
    localparam int     ROTATIONS      = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    localparam longint ARC [0:23] = '{
        51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2,
        1, 0, 0, 0, 0, 0, 0, 0
    };

    logic [DEADBAND_W-1:0]      deadband_q;
    logic [GAIN_W-1:0]          gain_q;
    longint                     held_yaw;
    logic signed [MOVE_W-1:0]   moves_due[$];
    logic signed [MOVE_W-1:0]   due_move;
    int                         errors;

    // vectoring rotation, angle in radians times 65536
    function automatic longint heading(input longint across, input longint along);
        longint px;
        longint py;
        longint pa;
        longint sx;
        longint sy;
        int     i;
        if (across == 0 && along == 0) return 0;
        px = along;
        py = across;
        pa = 0;
        if (px < 0) begin
            pa = (py >= 0) ? HALF_TURN : -HALF_TURN;
            px = -px;
            py = -py;
        end
        for (i = 0; i < ROTATIONS; i++) begin
            sx = px >>> i;
            sy = py >>> i;
            if (py >= 0) begin
                px += sy;
                py -= sx;
                pa += ARC[i];
            end else begin
                px -= sy;
                py += sx;
                pa -= ARC[i];
            end
        end
        if (pa > HALF_TURN) pa = HALF_TURN;
        if (pa < -HALF_TURN) pa = -HALF_TURN;
        return pa;
    endfunction

    function automatic void forecast_move(input longint w, input longint x,
                                          input longint y, input longint z);
        longint across;
        longint along;
        longint yaw;
        longint delta;
        longint mag;
        longint counts;
        across = 2 * (w * y + z * x);
        along  = (longint'(1) << 28) - 2 * (y * y + z * z);
        yaw    = heading(across, along);
        delta  = yaw - held_yaw;
        if (delta > HALF_TURN) delta -= FULL_TURN;
        if (delta < -HALF_TURN) delta += FULL_TURN;
        mag = (delta < 0) ? -delta : delta;
        if (mag <= longint'(deadband_q)) return;
        counts = (mag * longint'(gain_q)) >>> 16;
        if (counts > MOVE_LIMIT) counts = MOVE_LIMIT;
        if (delta < 0) counts = -counts;
        moves_due.push_back(MOVE_W'(counts));
        held_yaw = yaw;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            deadband_q = DEADBAND_W'(DEADBAND_INIT);
            gain_q     = GAIN_W'(GAIN_INIT);
            held_yaw   = 0;
            moves_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (moves_due.size() == 0) begin
                    $display("%0t move_x beat with nothing expected: expected none, got %0d",
                             $time, m_move_x);
                    errors++;
                end else begin
                    due_move = moves_due.pop_front();
                    if (m_move_x !== due_move) begin
                        $display("%0t move_x mismatch: expected %0d, got %0d",
                                 $time, due_move, m_move_x);
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_DEADBAND: deadband_q = cfg_data[DEADBAND_W-1:0];
                    REG_GAIN:     gain_q     = cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) forecast_move(s_quat_w, s_quat_x, s_quat_y, s_quat_z);
        end
        moves_pending  <= moves_due.size();
        mismatch_count <= errors;
    end

endmodule

>>> tb/tb_top.sv
// testbench top for the yaw-to-move core: clock, reset, quaternion and register stimulus, verdict
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import qymd_pkg::*;

    localparam int LIMIT_CYCLES    = 800000;
    localparam int SETTLE_CYCLES   = 48;
    localparam int HOLD_CYCLES     = 600;
    localparam int RANDOM_ROUNDS   = 6;
    localparam int ITEMS_PER_ROUND = 300;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(2);

    typedef enum int {ALWAYS_READY, MOSTLY_READY, HALF_READY, RARELY_READY} sink_style_t;

    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       s_valid   = 1'b0;
    logic                       s_ready;
    logic signed [QUAT_W-1:0]   s_quat_w  = '0;
    logic signed [QUAT_W-1:0]   s_quat_x  = '0;
    logic signed [QUAT_W-1:0]   s_quat_y  = '0;
    logic signed [QUAT_W-1:0]   s_quat_z  = '0;
    logic                       m_valid;
    logic                       m_ready   = 1'b0;
    logic signed [MOVE_W-1:0]   m_move_x;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data  = '0;
    int                         moves_pending;
    int                         mismatch_count;
    int                         cycle_count = 0;
    bit                         in_random = 1'b0;
    real                        head_yaw = 0.0;

    always #4 aclk = ~aclk;

    quaternion_yaw_to_mouse_delta_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_quat_w  (s_quat_w),
        .s_quat_x  (s_quat_x),
        .s_quat_y  (s_quat_y),
        .s_quat_z  (s_quat_z),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_move_x  (m_move_x),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    qymd_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_quat_w       (s_quat_w),
        .s_quat_x       (s_quat_x),
        .s_quat_y       (s_quat_y),
        .s_quat_z       (s_quat_z),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_move_x       (m_move_x),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .moves_pending  (moves_pending),
        .mismatch_count (mismatch_count)
    );

    task automatic send_quat(input int w, input int x, input int y, input int z);
        s_valid  <= 1'b1;
        s_quat_w <= QUAT_W'(w);
        s_quat_x <= QUAT_W'(x);
        s_quat_y <= QUAT_W'(y);
        s_quat_z <= QUAT_W'(z);
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic pause_sender(input int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // wait for every move, then for a beat that may still be in flight with no move
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (moves_pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic int to_q14(input real v);
        real r;
        r = v * 16384.0;
        return (r >= 0.0) ? $rtoi(r + 0.5) : -$rtoi(-r + 0.5);
    endfunction

    function automatic real rand_unit();
        return (real'($urandom_range(0, 200000)) / 100000.0) - 1.0;
    endfunction

    // unit quaternion with the given yaw and a tilt mixed into x and z
    task automatic send_pose(input real yaw, input real tilt);
        real cy;
        real sy;
        real ct;
        real st;
        cy = $cos(yaw / 2.0);
        sy = $sin(yaw / 2.0);
        ct = $cos(tilt / 2.0);
        st = $sin(tilt / 2.0);
        send_quat(to_q14(cy * ct), to_q14(cy * st), to_q14(sy * ct), to_q14(sy * st));
    endtask

    task automatic random_item();
        int  pick;
        real stride;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            case ($urandom_range(0, 3))
                0:       stride = 0.0005;
                1:       stride = 0.002;
                2:       stride = 0.05;
                default: stride = 0.8;
            endcase
            head_yaw += stride * rand_unit();
            send_pose(head_yaw, 0.4 * rand_unit());
        end else if (pick < 80) begin
            head_yaw = 3.14159 * rand_unit();
            send_pose(head_yaw, 1.5 * rand_unit());
        end else if (pick < 90) begin
            send_quat(int'($urandom_range(0, 65535)) - 32768,
                      int'($urandom_range(0, 65535)) - 32768,
                      int'($urandom_range(0, 65535)) - 32768,
                      int'($urandom_range(0, 65535)) - 32768);
        end else begin
            send_quat(int'($urandom_range(0, 32768)) - 16384,
                      int'($urandom_range(0, 32768)) - 16384,
                      int'($urandom_range(0, 32768)) - 16384,
                      int'($urandom_range(0, 32768)) - 16384);
        end
    endtask

    task automatic random_round(input int count);
        int sent;
        int burst;
        int i;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 40);
            for (i = 0; i < burst && sent < count; i++) begin
                random_item();
                sent++;
            end
            if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 30));
        end
    endtask

    task automatic configure_round(input int round);
        case (round)
            0: begin
                write_reg(REG_DEADBAND, CFG_DATA_W'($urandom_range(0, 300)));
                write_reg(REG_GAIN, CFG_DATA_W'($urandom_range(0, 4095)));
            end
            1: begin
                write_reg(REG_DEADBAND, CFG_DATA_W'(0));
                write_reg(REG_GAIN, CFG_DATA_W'(4095));
            end
            2: begin
                write_reg(REG_DEADBAND, CFG_DATA_W'(65535));
                write_reg(REG_GAIN, CFG_DATA_W'($urandom_range(0, 4095)));
            end
            3: begin
                write_reg(REG_DEADBAND, CFG_DATA_W'($urandom_range(0, 65535)));
                write_reg(REG_GAIN, CFG_DATA_W'(0));
            end
            4: begin
                write_reg(REG_DEADBAND, CFG_DATA_W'(66));
                write_reg(REG_GAIN, CFG_DATA_W'(1000));
            end
            default: begin
                write_reg(REG_DEADBAND, CFG_DATA_W'($urandom_range(0, 150)));
                write_reg(REG_GAIN, CFG_DATA_W'($urandom_range(0, 65535)));
            end
        endcase
        write_reg(CFG_IDX_W'($urandom_range(int'(REG_SPARE), 255)),
                  CFG_DATA_W'($urandom_range(0, 65535)));
    endtask

    initial begin : stimulus
        int round;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings
        send_quat(16384, 0, 0, 0);
        send_quat(11585, 0, 11585, 0);
        send_quat(0, 0, 16384, 0);
        send_quat(-1000, 0, 16384, 0);
        send_quat(1000, 0, 16384, 0);
        send_quat(0, 0, 8192, 8192);
        send_quat(16384, 0, 1, 0);
        send_quat(16384, 0, 8, 0);
        send_quat(16384, 0, 9, 0);
        send_quat(-32768, -32768, -32768, -32768);
        send_quat(32767, 32767, 32767, 32767);
        send_quat(-32768, 32767, -32768, 32767);
        send_quat(16384, 16384, 16384, 16384);
        send_quat(-16384, -16384, -16384, -16384);
        send_quat(8000, -9000, 3000, 12000);
        send_quat(0, 16384, 0, 0);
        send_quat(0, 0, 0, 16384);
        settle();

        // no deadband, full gain, data bits above the gain width set
        write_reg(REG_DEADBAND, CFG_DATA_W'(0));
        write_reg(REG_GAIN, CFG_DATA_W'(16'hFFFF));
        send_quat(0, 0, 0, 16384);
        send_quat(16384, 0, 0, 0);
        send_quat(16384, 0, 1, 0);
        send_quat(0, 0, 16384, 0);
        settle();

        write_reg(REG_DEADBAND, CFG_DATA_W'(16'hFFFF));
        write_reg(REG_GAIN, CFG_DATA_W'(0));
        write_reg(REG_SPARE, CFG_DATA_W'(16'h1234));
        send_quat(16384, 0, 0, 0);
        send_quat(11585, 0, 11585, 0);
        send_quat(14189, 0, 8192, 0);
        settle();

        in_random = 1'b1;
        for (round = 0; round < RANDOM_ROUNDS; round++) begin
            configure_round(round);
            random_round(ITEMS_PER_ROUND);
            settle();
        end

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin : receiver
        int          span;
        int          rounds_seen;
        bit          held;
        sink_style_t style;
        rounds_seen = 0;
        held = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (in_random && !held) begin
                rounds_seen++;
                // long back-pressure while beats keep coming
                if (rounds_seen == 3) begin
                    held = 1'b1;
                    m_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge aclk);
                end
            end
            span  = $urandom_range(10, 150);
            style = sink_style_t'($urandom_range(0, 3));
            repeat (span) begin
                case (style)
                    ALWAYS_READY: m_ready <= 1'b1;
                    MOSTLY_READY: m_ready <= ($urandom_range(0, 3) != 0);
                    HALF_READY:   m_ready <= ($urandom_range(0, 1) != 0);
                    default:      m_ready <= ($urandom_range(0, 5) == 0);
                endcase
                @(posedge aclk);
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> filelist.f
src/qymd_pkg.sv
src/qymd_mul.sv
src/qymd_cordic.sv
src/quaternion_yaw_to_mouse_delta_core.sv
tb/qymd_checker.sv
tb/tb_top.sv
